FILE: rtl/dm1bam_pkg.sv
// Shared types, codes and the fault record decoder for the DM1 transport decoder.
package dm1bam_pkg;

  localparam int unsigned SPN_W = 19;
  localparam int unsigned FMI_W = 5;
  localparam int unsigned OCC_W = 7;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ROW_W = 56;

  localparam logic [7:0] BAM_CONTROL = 8'h20;
  localparam logic [7:0] DM1_PGN_LO = 8'hCA;
  localparam logic [7:0] DM1_PGN_MID = 8'hFE;
  localparam logic [7:0] DM1_PGN_HI = 8'h00;

  typedef enum logic [1:0] {
    OP_SINGLE = 2'd0,
    OP_ANNOUNCE = 2'd1,
    OP_DATA = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_issue;
    logic rd_shift;
    logic emit_single;
    logic emit_rec;
  } dp_cmd_t;

  typedef struct packed {
    logic is_single;
    logic single_hit;
    logic decode_go;
    logic byte_last;
    logic rec_last;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic [SPN_W-1:0] spn;
    logic [FMI_W-1:0] fmi;
    logic [OCC_W-1:0] occ;
    logic conv;
  } rec_t;

  function automatic rec_t decode_rec(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3);
    rec_t r;
    r.conv = b3[7];
    if (b3[7]) begin
      r.spn = {b0, b1, b2[7:5]};
    end else begin
      r.spn = {b2[7:5], b1, b0};
    end
    r.fmi = b2[4:0];
    r.occ = b3[6:0];
    return r;
  endfunction

endpackage

FILE: rtl/dm1bam_if.sv
// Valid/ready channel interfaces for CAN frames in and fault records out.
interface dm1bam_in_if;
  import dm1bam_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic [DATA_W-1:0] frame_data;
  modport source (output valid, output opcode, output frame_data, input ready);
  modport sink (input valid, input opcode, input frame_data, output ready);
endinterface

interface dm1bam_out_if;
  import dm1bam_pkg::*;
  logic valid;
  logic ready;
  logic [SPN_W-1:0] spn;
  logic [FMI_W-1:0] fmi;
  logic [OCC_W-1:0] occurrence;
  logic conversion_method;
  logic from_multi_packet;
  logic last_of_run;
  modport source (output valid, output spn, output fmi, output occurrence,
                  output conversion_method, output from_multi_packet,
                  output last_of_run, input ready);
  modport sink (input valid, input spn, input fmi, input occurrence,
                input conversion_method, input from_multi_packet,
                input last_of_run, output ready);
endinterface

FILE: rtl/dm1bam_dp.sv
// Datapath: frame register, transport state, reassembly memory, record assembly and output register.
module dm1bam_dp #(
  parameter int unsigned MAX_FAULTS = 10,
  parameter int unsigned MAX_PACKETS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          opcode_i,
  input  logic [63:0]         frame_data_i,
  input  dm1bam_pkg::dp_cmd_t cmd_i,
  output dm1bam_pkg::dp_status_t status_o,
  dm1bam_out_if.source        out_o
);
  import dm1bam_pkg::*;

  localparam int unsigned FT_W = $clog2(MAX_FAULTS + 1);
  localparam int unsigned PT_W = $clog2(MAX_PACKETS + 1);
  localparam int unsigned PKT_AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int unsigned ROW_MAX = (4 * MAX_FAULTS + 6) / 7;
  localparam int unsigned ROW_CW = $clog2(ROW_MAX + 1);
  localparam int unsigned PTR_W = (ROW_CW > PKT_AW) ? ROW_CW : PKT_AW;

  logic [1:0]        op_q;
  logic [63:0]       fd_q;
  logic [63:0]       last_ann_q, last_ann_d;
  logic              ann_seen_q, ann_seen_d;
  logic [FT_W-1:0]   ft_q, ft_d;
  logic [PT_W-1:0]   pt_q, pt_d;
  logic [PT_W-1:0]   pr_q, pr_d;
  logic [MAX_PACKETS-1:0] row_vld_q, row_vld_d;

  logic [ROW_W-1:0]  mem [MAX_PACKETS];
  logic [ROW_W-1:0]  rd_q;
  logic              rvld_q;
  logic [2:0]        rcol_q;

  logic [PTR_W-1:0]  row_q, row_d;
  logic [2:0]        col_q, col_d;
  logic [1:0]        nib_q, nib_d;
  logic [31:0]       rec_q, rec_d;
  logic [FT_W-1:0]   ridx_q, ridx_d;

  logic              out_vld_q, out_vld_d;
  rec_t              out_rec_q, out_rec_d;
  logic              out_multi_q, out_multi_d;
  logic              out_last_q, out_last_d;

  logic              ann_ok;
  logic [15:0]       size;
  logic [15:0]       size_m2;
  logic [13:0]       faults;
  logic [7:0]        seq;
  logic              seq_ok;
  logic              pkt_open;
  logic              wr_en;
  logic [PKT_AW-1:0] wr_row;
  logic [7:0]        sel_byte;
  logic              row_in_range;
  rec_t              single_rec;
  logic              load_out;

  assign size = {fd_q[23:16], fd_q[15:8]};
  assign size_m2 = size - 16'd2;
  assign faults = (size < 16'd6) ? 14'd0 : size_m2[15:2];
  assign ann_ok = (fd_q[7:0] == BAM_CONTROL) && (fd_q[47:40] == DM1_PGN_LO) &&
                  (fd_q[55:48] == DM1_PGN_MID) && (fd_q[63:56] == DM1_PGN_HI) &&
                  !(ann_seen_q && (fd_q == last_ann_q));
  assign seq = fd_q[7:0];
  assign seq_ok = (seq != 8'd0) && (seq <= 8'(pt_q));
  assign pkt_open = pr_q < pt_q;
  assign wr_en = cmd_i.exec && (op_q == OP_DATA) && pkt_open && seq_ok;
  assign wr_row = PKT_AW'(seq - 8'd1);
  assign row_in_range = row_q < PTR_W'(MAX_PACKETS);
  assign sel_byte = rvld_q ? rd_q[{rcol_q, 3'b000} +: 8] : 8'd0;
  assign single_rec = decode_rec(fd_q[23:16], fd_q[31:24], fd_q[39:32], fd_q[47:40]);
  assign load_out = cmd_i.emit_single || cmd_i.emit_rec;

  assign status_o.is_single = op_q == OP_SINGLE;
  assign status_o.single_hit = (|fd_q[47:0]) &&
                               ((single_rec.spn != '0) || (single_rec.fmi != '0));
  assign status_o.decode_go = (op_q == OP_DATA) && pkt_open &&
                              (PT_W'(pr_q + PT_W'(1)) == pt_q) && (ft_q >= FT_W'(2));
  assign status_o.byte_last = nib_q == 2'd3;
  assign status_o.rec_last = FT_W'(ridx_q + FT_W'(1)) == ft_q;
  assign status_o.out_free = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      fd_q <= frame_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_row] <= fd_q[63:8];
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem[row_q[PKT_AW-1:0]];
    end
  end

  always_comb begin
    last_ann_d = last_ann_q;
    ann_seen_d = ann_seen_q;
    ft_d = ft_q;
    pt_d = pt_q;
    pr_d = pr_q;
    row_vld_d = row_vld_q;
    if (cmd_i.exec) begin
      case (op_q)
        OP_ANNOUNCE: begin
          if (ann_ok) begin
            last_ann_d = fd_q;
            ann_seen_d = 1'b1;
            ft_d = (faults > 14'(MAX_FAULTS)) ? FT_W'(MAX_FAULTS) : FT_W'(faults);
            pt_d = (fd_q[31:24] > 8'(MAX_PACKETS)) ? PT_W'(MAX_PACKETS)
                                                   : PT_W'(fd_q[31:24]);
            pr_d = '0;
            row_vld_d = '0;
          end
        end
        OP_DATA: begin
          if (pkt_open) begin
            pr_d = PT_W'(pr_q + PT_W'(1));
            if (seq_ok) begin
              row_vld_d[wr_row] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    nib_d = nib_q;
    rec_d = rec_q;
    ridx_d = ridx_q;
    if (cmd_i.exec && status_o.decode_go) begin
      row_d = '0;
      col_d = 3'd2;
      nib_d = '0;
      ridx_d = '0;
    end
    if (cmd_i.rd_shift) begin
      rec_d = {sel_byte, rec_q[31:8]};
      nib_d = nib_q + 2'd1;
      if (col_q == 3'd6) begin
        col_d = '0;
        row_d = PTR_W'(row_q + PTR_W'(1));
      end else begin
        col_d = col_q + 3'd1;
      end
    end
    if (cmd_i.emit_rec) begin
      ridx_d = FT_W'(ridx_q + FT_W'(1));
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_rec_d = out_rec_q;
    out_multi_d = out_multi_q;
    out_last_d = out_last_q;
    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
      if (cmd_i.emit_single) begin
        out_rec_d = single_rec;
        out_multi_d = 1'b0;
        out_last_d = 1'b1;
      end else begin
        out_rec_d = decode_rec(rec_q[7:0], rec_q[15:8], rec_q[23:16], rec_q[31:24]);
        out_multi_d = 1'b1;
        out_last_d = status_o.rec_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ann_q <= '0;
      ann_seen_q <= 1'b0;
      ft_q <= '0;
      pt_q <= '0;
      pr_q <= '0;
      row_vld_q <= '0;
      rvld_q <= 1'b0;
      rcol_q <= '0;
      row_q <= '0;
      col_q <= '0;
      nib_q <= '0;
      ridx_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      last_ann_q <= last_ann_d;
      ann_seen_q <= ann_seen_d;
      ft_q <= ft_d;
      pt_q <= pt_d;
      pr_q <= pr_d;
      row_vld_q <= row_vld_d;
      if (cmd_i.rd_issue) begin
        rvld_q <= row_in_range && row_vld_q[row_q[PKT_AW-1:0]];
        rcol_q <= col_q;
      end
      row_q <= row_d;
      col_q <= col_d;
      nib_q <= nib_d;
      ridx_q <= ridx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    out_rec_q <= out_rec_d;
    out_multi_q <= out_multi_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.spn = out_rec_q.spn;
  assign out_o.fmi = out_rec_q.fmi;
  assign out_o.occurrence = out_rec_q.occ;
  assign out_o.conversion_method = out_rec_q.conv;
  assign out_o.from_multi_packet = out_multi_q;
  assign out_o.last_of_run = out_last_q;

  a_pr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) pr_q <= pt_q)
    else $error("Received packet count exceeds the announced packet count.");
  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_q <= PT_W'(MAX_PACKETS)) && (ft_q <= FT_W'(MAX_FAULTS)))
    else $error("Announced totals exceed their limits.");
  a_ridx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_rec |-> (ridx_q < ft_q))
    else $error("A record was emitted beyond the announced fault count.");

endmodule

FILE: rtl/dm1bam_ctrl.sv
// Controller: sequences frame capture, execution, buffer reads and record emission.
module dm1bam_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dm1bam_pkg::dp_status_t status_i,
  output dm1bam_pkg::dp_cmd_t    cmd_o
);
  import dm1bam_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status_i.is_single) begin
          if (!status_i.single_hit || status_i.out_free) begin
            state_d = ST_IDLE;
          end
        end else if (status_i.decode_go) begin
          state_d = ST_RD_ADDR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: begin
        state_d = status_i.byte_last ? ST_EMIT : ST_RD_ADDR;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = status_i.rec_last ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        if (status_i.is_single) begin
          cmd_o.emit_single = status_i.single_hit && status_i.out_free;
        end else begin
          cmd_o.exec = 1'b1;
        end
      end
      ST_RD_ADDR: cmd_o.rd_issue = 1'b1;
      ST_RD_DATA: cmd_o.rd_shift = 1'b1;
      ST_EMIT: cmd_o.emit_rec = status_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_rec || cmd_o.emit_single) |-> status_i.out_free)
    else $error("Output register loaded while still occupied.");
  a_shift_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_shift |-> $past(cmd_o.rd_issue))
    else $error("Byte shifted without a preceding buffer read.");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> !cmd_o.exec)
    else $error("A frame was executed twice.");

endmodule

FILE: rtl/j1939_dm1_bam_dtc_decoder.sv
// Top level of the DM1 fault record decoder for single frames and BAM transport.
// A frame is captured in the idle state and executed in the state after it; a single-frame
// record goes into the output register from the execute state, which waits while it is full.
// A final data packet emits its records, up to MAX_FAULTS, one at a time: four reassembly
// memory reads (a read-address and a read-data state each), then an emit state that likewise
// waits for a free output register. No new frame is taken until the last record is out.
// Asynchronous active-low reset empties the buffer, transport state and output register.
module j1939_dm1_bam_dtc_decoder #(
  parameter int unsigned MAX_FAULTS = 10,
  parameter int unsigned MAX_PACKETS = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dm1bam_in_if.sink     in_i,
  dm1bam_out_if.source  out_o
);
  import dm1bam_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dm1bam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dm1bam_dp #(
    .MAX_FAULTS  (MAX_FAULTS),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .opcode_i     (in_i.opcode),
    .frame_data_i (in_i.frame_data),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_o        (out_o)
  );

endmodule

FILE: tb/sv/dm1bam_checker.sv
// Checker that predicts the fault records of the DM1 decoder and compares them on the output.
`timescale 1ns / 100ps

module dm1bam_checker #(
  parameter int unsigned MAX_FAULTS = 10,
  parameter int unsigned MAX_PACKETS = 6
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dm1bam_in_if  in_i,
  dm1bam_out_if out_i,
  output int    fail_count_o,
  output int    pending_o,
  output int    checked_o
);
  import dm1bam_pkg::*;

  localparam int unsigned BUF_BYTES = MAX_PACKETS * 7;

  typedef struct {
    logic [SPN_W-1:0] spn;
    logic [FMI_W-1:0] fmi;
    logic [OCC_W-1:0] occ;
    logic             conv;
    logic             multi;
    logic             last;
  } dtc_t;

  dtc_t        dtc_q[$];
  logic [7:0]  msg_buf[BUF_BYTES];
  logic [63:0] last_bam;
  logic        bam_seen;
  int unsigned fault_cnt;
  int unsigned pkt_cnt;
  int unsigned pkt_rcvd;
  int          errors;
  int          checked;

  assign fail_count_o = errors;
  assign pending_o = dtc_q.size();
  assign checked_o = checked;

  initial begin
    foreach (msg_buf[i]) msg_buf[i] = 8'h00;
    last_bam = '0;
    bam_seen = 1'b0;
    fault_cnt = 0;
    pkt_cnt = 0;
    pkt_rcvd = 0;
    errors = 0;
    checked = 0;
  end

  function automatic dtc_t make_dtc(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic multi, input logic last);
    dtc_t r;
    int unsigned v;
    r.conv = b3[7];
    if (b3[7]) begin
      v = (int'(b0) << 11) | (int'(b1) << 3) | (int'(b2) >> 5);
    end else begin
      v = int'(b0) | (int'(b1) << 8) | ((int'(b2) >> 5) << 16);
    end
    r.spn = v[SPN_W-1:0];
    r.fmi = b2[4:0];
    r.occ = b3[6:0];
    r.multi = multi;
    r.last = last;
    return r;
  endfunction

  function automatic logic [7:0] buf_rd(input int unsigned idx);
    return (idx < BUF_BYTES) ? msg_buf[idx] : 8'h00;
  endfunction

  task automatic decode_frame(input logic [1:0] op, input logic [63:0] d);
    dtc_t r;
    int unsigned size;
    int unsigned nf;
    int unsigned seq;
    int unsigned base;
    int unsigned k;
    case (op)
      OP_SINGLE: begin
        if (d[47:0] != '0) begin
          r = make_dtc(d[23:16], d[31:24], d[39:32], d[47:40], 1'b0, 1'b1);
          if (r.spn != '0 || r.fmi != '0) dtc_q.push_back(r);
        end
      end
      OP_ANNOUNCE: begin
        if (d[7:0] == BAM_CONTROL && d[47:40] == DM1_PGN_LO && d[55:48] == DM1_PGN_MID &&
            d[63:56] == DM1_PGN_HI && !(bam_seen && d == last_bam)) begin
          bam_seen = 1'b1;
          last_bam = d;
          size = 32'({d[23:16], d[15:8]});
          nf = (size < 6) ? 0 : (size - 2) / 4;
          fault_cnt = (nf < MAX_FAULTS) ? nf : MAX_FAULTS;
          pkt_cnt = (32'(d[31:24]) < MAX_PACKETS) ? 32'(d[31:24]) : MAX_PACKETS;
          foreach (msg_buf[i]) msg_buf[i] = 8'h00;
          pkt_rcvd = 0;
        end
      end
      OP_DATA: begin
        if (pkt_rcvd < pkt_cnt) begin
          pkt_rcvd++;
          seq = 32'(d[7:0]);
          if (seq >= 1 && seq <= pkt_cnt) begin
            base = (seq - 1) * 7;
            for (int i = 0; i < 7; i++) begin
              if (base + i < BUF_BYTES) msg_buf[base + i] = d[8*(i+1) +: 8];
            end
          end
          if (pkt_rcvd == pkt_cnt && fault_cnt >= 2) begin
            for (int unsigned i = 0; i < fault_cnt; i++) begin
              k = i * 4 + 2;
              dtc_q.push_back(make_dtc(buf_rd(k), buf_rd(k + 1), buf_rd(k + 2), buf_rd(k + 3),
                                       1'b1, (i + 1 == fault_cnt)));
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    dtc_t want;
    dtc_t got;
    if (rst_ni) begin
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) begin
        got.spn = out_i.spn;
        got.fmi = out_i.fmi;
        got.occ = out_i.occurrence;
        got.conv = out_i.conversion_method;
        got.multi = out_i.from_multi_packet;
        got.last = out_i.last_of_run;
        checked++;
        if (dtc_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected record: spn=%0h fmi=%0h occ=%0h conv=%0b multi=%0b last=%0b",
                     got.spn, got.fmi, got.occ, got.conv, got.multi, got.last);
          end
        end else begin
          want = dtc_q.pop_front();
          if (got.spn !== want.spn || got.fmi !== want.fmi || got.occ !== want.occ ||
              got.conv !== want.conv || got.multi !== want.multi || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("record mismatch: expected spn=%0h fmi=%0h occ=%0h conv=%0b multi=%0b last=%0b",
                       want.spn, want.fmi, want.occ, want.conv, want.multi, want.last);
              $display("                 actual   spn=%0h fmi=%0h occ=%0h conv=%0b multi=%0b last=%0b",
                       got.spn, got.fmi, got.occ, got.conv, got.multi, got.last);
            end
          end
        end
      end
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) decode_frame(in_i.opcode, in_i.frame_data);
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the testbench: clock, reset, frame stimulus, output stalls and the verdict.
`timescale 1ns / 100ps

module testbench;
  import dm1bam_pkg::*;

  localparam int unsigned N_FAULTS = 10;
  localparam int unsigned N_PACKETS = 6;
  localparam int LIMIT = 400000;
  localparam int DRAIN = 200;
  localparam int PHASE_ITEMS = 55;

  logic clk;
  logic rst_n;
  logic in_fire = 1'b0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   frames_sent = 0;
  int   useful = 0;
  int   fail_count;
  int   pending;
  int   checked;

  dm1bam_in_if in_ch ();
  dm1bam_out_if out_ch ();

  j1939_dm1_bam_dtc_decoder #(
    .MAX_FAULTS (N_FAULTS),
    .MAX_PACKETS(N_PACKETS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  dm1bam_checker #(
    .MAX_FAULTS (N_FAULTS),
    .MAX_PACKETS(N_PACKETS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_fire <= in_ch.valid && in_ch.ready;
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles with %0d records outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [55:0] rand56();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[55:0];
  endfunction

  function automatic logic [63:0] bam_announce(input logic [15:0] size, input logic [7:0] pk,
                                               input logic [7:0] b4);
    return {DM1_PGN_HI, DM1_PGN_MID, DM1_PGN_LO, b4, pk, size, BAM_CONTROL};
  endfunction

  task automatic send_frame(input logic [1:0] op, input logic [63:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.frame_data <= d;
    do @(negedge clk); while (in_fire !== 1'b1);
    frames_sent++;
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_bam_message();
    logic [15:0] size;
    logic [7:0]  pk;
    logic [7:0]  seq;
    logic [63:0] ann;
    int          npk;
    int          nsend;
    size = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
    pk = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    ann = bam_announce(size, pk, 8'($urandom));
    send_frame(OP_ANNOUNCE, ann);
    useful++;
    if ($urandom_range(9) == 0) send_frame(OP_ANNOUNCE, ann);
    npk = (pk > N_PACKETS) ? N_PACKETS : pk;
    nsend = ($urandom_range(7) == 0) ? $urandom_range(0, npk) : npk;
    for (int s = 1; s <= nsend; s++) begin
      seq = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(s);
      send_frame(OP_DATA, {rand56(), seq});
      useful++;
    end
  endtask

  initial begin
    int idle_set[4];
    int stall_set[4];
    int sel;
    logic [63:0] ann;
    logic [63:0] mask;
    idle_set = '{0, 75, 0, 19};
    stall_set = '{0, 0, 75, 19};
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_SINGLE;
    in_ch.frame_data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_frame(OP_SINGLE, 64'h0);
    send_frame(OP_SINGLE, 64'hFFFF_0000_0000_0001);
    send_frame(OP_SINGLE, 64'h0000_8500_0000_0000);
    send_frame(OP_SINGLE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(OP_SINGLE, 64'h0000_7FFF_FFFF_0000);
    send_frame(OP_SINGLE, 64'h0000_0001_0000_0000);
    send_frame(2'd3, rand64());
    send_frame(OP_ANNOUNCE, bam_announce(16'd14, 8'd2, 8'h00) ^ 64'h1);
    send_frame(OP_ANNOUNCE, bam_announce(16'd14, 8'd2, 8'h00) ^ (64'h1 << 40));
    send_frame(OP_ANNOUNCE, bam_announce(16'd6, 8'd1, 8'h00));
    send_frame(OP_DATA, {56'hFF_FFFF_FFFF_FFFF, 8'd1});
    send_frame(OP_ANNOUNCE, bam_announce(16'd5, 8'd2, 8'h00));
    send_frame(OP_DATA, {rand56(), 8'd1});
    send_frame(OP_DATA, {rand56(), 8'd2});
    ann = bam_announce(16'hFFFF, 8'hFF, 8'hFF);
    send_frame(OP_ANNOUNCE, ann);
    send_frame(OP_ANNOUNCE, ann);
    send_frame(OP_DATA, {56'hFF_FFFF_FFFF_FFFF, 8'd6});
    send_frame(OP_DATA, {rand56(), 8'd0});
    send_frame(OP_DATA, {rand56(), 8'd2});
    send_frame(OP_DATA, {rand56(), 8'd7});
    send_frame(OP_DATA, {rand56(), 8'd4});
    send_frame(OP_DATA, {rand56(), 8'hFF});
    send_frame(OP_DATA, {rand56(), 8'd3});
    send_frame(OP_ANNOUNCE, bam_announce(16'd42, 8'd6, 8'h00));
    for (int s = 1; s <= N_PACKETS; s++) send_frame(OP_DATA, {rand56(), 8'(s)});
    send_frame(OP_ANNOUNCE, bam_announce(16'd20, 8'd0, 8'h00));
    send_frame(OP_DATA, {rand56(), 8'd1});
    send_frame(OP_ANNOUNCE, bam_announce(16'd10, 8'd2, 8'h00));
    send_frame(OP_DATA, {rand56(), 8'd1});
    send_frame(OP_DATA, {rand56(), 8'd2});
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        sel = $urandom_range(99);
        if (sel < 60) begin
          send_bam_message();
        end else if (sel < 85) begin
          mask = {{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                  {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                  {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                  {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}}};
          send_frame(OP_SINGLE, rand64() & mask);
          useful++;
        end else begin
          send_frame(2'($urandom_range(0, 3)), rand64());
        end
      end
      wait_quiet();
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    $display("Sent %0d CAN frames (single, announce, data and noise) and checked %0d records,",
             frames_sent, checked);
    $display("over four phases of sender gaps and receiver stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/dm1bam_pkg.sv
rtl/dm1bam_if.sv
rtl/dm1bam_dp.sv
rtl/dm1bam_ctrl.sv
rtl/j1939_dm1_bam_dtc_decoder.sv
tb/sv/dm1bam_checker.sv
tb/sv/testbench.sv
